### rtl/core/mcdc_pkg.sv
package mcdc_pkg;

   localparam int unsigned YearWidth  = 16;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned CountWidth = 25;
   localparam int unsigned LeapWidth  = 14;
   localparam int unsigned QuotWidth  = 10;

   localparam logic [YearWidth-1:0]  EPOCH_YEAR     = 16'd2014;
   localparam logic [YearWidth-1:0]  EPOCH_YEAR_M1  = 16'd2013;
   localparam logic [CountWidth-1:0] DAYS_PER_YEAR  = 25'd365;
   // leaps up to 2013 (488) less 4
   localparam logic [CountWidth-1:0] AFTER_OFFSET   = 25'd484;
   // leaps up to 2013 (488) plus 27 days of December
   localparam logic [CountWidth-1:0] BEFORE_OFFSET  = 25'd515;
   // reciprocal of 100, exact for any 16-bit year at a shift of 23
   localparam logic [16:0]           RECIP_100      = 17'd83887;
   localparam int unsigned           RECIP_SHIFT    = 23;
   localparam logic [MonthWidth-1:0] MONTH_FEB      = 4'd2;
   localparam logic [MonthWidth-1:0] MONTH_DEC      = 4'd12;

   typedef struct packed {
      logic [YearWidth-1:0]  year;
      logic [MonthWidth-1:0] month;
   } req_type;

   typedef struct packed {
      logic [CountWidth-1:0] day_count;
      logic                  before_epoch;
      logic [2:0]            first_weekday;
      logic [4:0]            month_length;
      logic                  invalid;
   } rsp_type;

   function automatic logic [4:0] month_len(input logic [MonthWidth-1:0] m,
                                            input logic leap);
      logic [4:0] len;
      case (m)
         4'd2:                       len = leap ? 5'd29 : 5'h1C;
         4'd4, 4'd6, 4'd9, 4'd11:    len = 5'h1E;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:         len = 5'h1F;
         default:                    len = 5'd0;
      endcase
      return len;
   endfunction

   // 8 = 1 mod 7, so octal digits fold down to the residue
   function automatic logic [2:0] mod7(input logic [CountWidth-1:0] v);
      logic [26:0] p;
      logic [5:0]  s;
      logic [3:0]  t;
      logic [3:0]  u;
      p = {2'b00, v};
      s = '0;
      for (int i = 0; i < 9; i++) begin
         s = s + {3'b000, p[3*i +: 3]};
      end
      t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
      u = {3'b000, t[3]} + {1'b0, t[2:0]};
      return (u == 4'd7) ? 3'd0 : u[2:0];
   endfunction

endpackage

### rtl/core/month_calendar_day_count.sv
// A transaction runs through the divide, remainder, year, leap, month and weekday
//    states; the month state adds the length of each month summed (up to 11).
//    An invalid month goes from divide straight to weekday. A new transaction is
//    taken only in idle; a stalled result holds the next one in its final step.
// Reset: synchronous, active high; returns the sequencer to idle and drops
//    rsp_valid. Result registers are not reset.
module month_calendar_day_count
   import mcdc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_REM   = 7'b0000100,
      ST_YEAR  = 7'b0001000,
      ST_LEAP  = 7'b0010000,
      ST_MONTH = 7'b0100000,
      ST_WDAY  = 7'b1000000
   } state_type;

   localparam state_type ST_DONE_UNUSED = ST_IDLE;

   state_type             state_ff, state_in;
   logic                  done_ff, done_in;
   logic [YearWidth-1:0]  year_ff;
   logic [MonthWidth-1:0] month_ff;
   logic                  before_ff;
   logic                  bad_ff;
   logic [QuotWidth-1:0]  q_ff, q_in;
   logic [6:0]            r_ff, r_in;
   logic [CountWidth-1:0] acc_ff, acc_in;
   logic [MonthWidth-1:0] m_ff, m_in;
   rsp_type               rsp_ff, rsp_in;

   logic [32:0]           prod;
   logic [16:0]           hundreds;
   logic                  leap;
   logic [YearWidth-1:0]  diff;
   logic [YearWidth-1:0]  arg;
   logic [QuotWidth-1:0]  qa;
   logic [LeapWidth-1:0]  leaps;
   logic [CountWidth-1:0] operand;
   logic [MonthWidth-1:0] m_end;
   logic [2:0]            res7;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = done_ff;
   assign rsp_data  = rsp_ff;

   assign prod     = 33'(year_ff) * 33'(RECIP_100);
   assign hundreds = 17'(q_ff) * 17'd100;
   assign leap     = (year_ff[1:0] == 2'b00) && ((r_ff != 7'd0) || (q_ff[1:0] == 2'b00));
   assign diff     = before_ff ? (EPOCH_YEAR_M1 - year_ff) : (year_ff - EPOCH_YEAR);
   // from 2014 the leap count runs up to the previous year
   assign arg      = before_ff ? year_ff : (year_ff - 16'd1);
   assign qa       = q_ff - QuotWidth'(!before_ff && (r_ff == 7'd0));
   assign leaps    = LeapWidth'(arg >> 2) - LeapWidth'(qa) + LeapWidth'(qa >> 2);
   assign m_end    = before_ff ? MONTH_DEC : month_ff;
   assign res7     = mod7(acc_ff);

   // operand of the shared accumulator adder
   always_comb begin
      case (state_ff)
         ST_LEAP:  operand = before_ff ? (BEFORE_OFFSET - CountWidth'(leaps))
                                       : (CountWidth'(leaps) - AFTER_OFFSET);
         ST_MONTH: operand = CountWidth'(month_len(m_ff, leap));
         default:  operand = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      acc_in   = acc_ff;
      m_in     = m_ff;
      rsp_in   = rsp_ff;
      if (done_ff && rsp_ready) begin
         done_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            q_in     = prod[RECIP_SHIFT +: QuotWidth];
            state_in = bad_ff ? ST_WDAY : ST_REM;
         end
         ST_REM: begin
            r_in     = 7'(year_ff - hundreds[YearWidth-1:0]);
            state_in = ST_YEAR;
         end
         ST_YEAR: begin
            acc_in   = CountWidth'(diff) * DAYS_PER_YEAR;
            m_in     = before_ff ? month_ff : 4'd1;
            state_in = ST_LEAP;
         end
         ST_LEAP: begin
            acc_in   = acc_ff + operand;
            state_in = ST_MONTH;
         end
         ST_MONTH: begin
            if (m_ff == m_end) begin
               state_in = ST_WDAY;
            end else begin
               acc_in = acc_ff + operand;
               m_in   = m_ff + 4'd1;
            end
         end
         ST_WDAY: begin
            // wait here while the previous result is still unclaimed
            if (!done_ff || rsp_ready) begin
               rsp_in.before_epoch = before_ff;
               rsp_in.invalid      = bad_ff;
               if (bad_ff) begin
                  rsp_in.day_count     = '0;
                  rsp_in.first_weekday = 3'd0;
                  rsp_in.month_length  = 5'd0;
               end else begin
                  rsp_in.day_count     = acc_ff;
                  rsp_in.month_length  = month_len(month_ff, leap);
                  // count - 1 mod 7 from 2014, else 6 - count mod 7
                  if (before_ff) begin
                     rsp_in.first_weekday = 3'd6 - res7;
                  end else begin
                     rsp_in.first_weekday = (res7 == 3'd0) ? 3'd6 : (res7 - 3'd1);
                  end
               end
               done_in  = 1'b1;
               state_in = ST_DONE_UNUSED;
            end
         end
         default: begin
            state_in = ST_IDLE;
            done_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         year_ff   <= req_data.year;
         month_ff  <= req_data.month;
         before_ff <= req_data.year < EPOCH_YEAR;
         bad_ff    <= (req_data.month == 4'd0) || (req_data.month > MONTH_DEC);
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      acc_ff <= acc_in;
      m_ff   <= m_in;
      rsp_ff <= rsp_in;
   end

   a_ready_not_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request accepted while the sequencer is busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready && (state_ff == ST_DIV))
      else $error("sequencer did not start after a request");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.invalid) |->
         (rsp_data.day_count == '0) && (rsp_data.month_length == 5'd0))
      else $error("invalid month gave a non-zero result");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.invalid) |->
         (rsp_data.month_length >= 5'd28) && (rsp_data.first_weekday <= 3'd6))
      else $error("month length or weekday out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_month_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTH) |-> (m_ff <= MONTH_DEC) && (m_ff >= 4'd1))
      else $error("month counter out of range");

endmodule

### sim/calendar_checker.sv
`timescale 1ns / 1ps

module calendar_checker
   import mcdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   output int unsigned failures,
   output int unsigned outstanding
);

   localparam int unsigned DAYS_IN_YEAR    = 365;
   localparam int unsigned FIRST_OF_2014   = 4;   // 2014-01-01, epoch day being 1
   localparam int unsigned DECEMBER_TO_EPOCH = 27;

   typedef struct {
      req_type query;
      rsp_type answer;
   } dated_answer_type;

   dated_answer_type awaited_answers[$];

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   function automatic int unsigned leaps_through(input int unsigned y);
      return y / 4 - y / 100 + y / 400;
   endfunction

   function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
      int unsigned len;
      case (m)
         1, 3, 5, 7, 8, 10, 12: len = 31;
         4, 6, 9, 11:           len = 30;
         2:                     len = leap ? 29 : 28;
         default:               len = 0;
      endcase
      return len;
   endfunction

   function automatic rsp_type predict_calendar(input req_type q);
      rsp_type     r;
      int unsigned y;
      int unsigned m;
      int unsigned total;
      int unsigned k;
      bit          leap;
      y = q.year;
      m = q.month;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      r = '0;
      r.before_epoch = (q.year < EPOCH_YEAR);
      r.invalid = (m == 0) || (m > MONTH_DEC);
      if (!r.invalid) begin
         r.month_length = 5'(days_in_month(m, leap));
         if (!r.before_epoch) begin
            total = FIRST_OF_2014 + DAYS_IN_YEAR * (y - EPOCH_YEAR)
                  + leaps_through(y - 1) - leaps_through(EPOCH_YEAR_M1);
            for (k = 1; k < m; k++) begin
               total += days_in_month(k, leap);
            end
            r.first_weekday = 3'((total - 1) % 7);
         end else begin
            // whole years after this one, rest of this year, then December up to the epoch
            total = DAYS_IN_YEAR * (EPOCH_YEAR_M1 - y)
                  + leaps_through(EPOCH_YEAR_M1) - leaps_through(y);
            for (k = m; k < MONTH_DEC; k++) begin
               total += days_in_month(k, leap);
            end
            total += DECEMBER_TO_EPOCH;
            r.first_weekday = 3'(6 - total % 7);
         end
         r.day_count = total[CountWidth-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      failures++;
   endtask

   task automatic check_answer(input dated_answer_type e, input rsp_type got);
      string tag;
      tag = $sformatf("year %0d month %0d:", e.query.year, e.query.month);
      if (got.day_count !== e.answer.day_count)
         report_mismatch($sformatf("%s day_count %0d, expected %0d",
                                   tag, got.day_count, e.answer.day_count));
      if (got.before_epoch !== e.answer.before_epoch)
         report_mismatch($sformatf("%s before_epoch %0b, expected %0b",
                                   tag, got.before_epoch, e.answer.before_epoch));
      if (got.first_weekday !== e.answer.first_weekday)
         report_mismatch($sformatf("%s first_weekday %0d, expected %0d",
                                   tag, got.first_weekday, e.answer.first_weekday));
      if (got.month_length !== e.answer.month_length)
         report_mismatch($sformatf("%s month_length %0d, expected %0d",
                                   tag, got.month_length, e.answer.month_length));
      if (got.invalid !== e.answer.invalid)
         report_mismatch($sformatf("%s invalid %0b, expected %0b",
                                   tag, got.invalid, e.answer.invalid));
   endtask

   always @(posedge clock) begin
      dated_answer_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch($sformatf("result transaction with nothing pending, day_count %0d",
                                         rsp_data.day_count));
            end else begin
               e = awaited_answers.pop_front();
               check_answer(e, rsp_data);
            end
         end
         if (req_valid && req_ready) begin
            e.query  = req_data;
            e.answer = predict_calendar(req_data);
            awaited_answers.push_back(e);
         end
      end
      outstanding <= awaited_answers.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import mcdc_pkg::*;

   localparam int unsigned RANDOM_QUERIES = 550;
   localparam int unsigned STALL_LIMIT    = 4000;
   localparam int unsigned DRAIN_CYCLES   = 40;
   localparam int unsigned IDLE_PERCENT   = 17;
   localparam int unsigned QUIET_FIRST    = 300;
   localparam int unsigned QUIET_LAST     = 400;
   localparam int unsigned PAUSE_AT       = 450;
   localparam int unsigned HOLD_AFTER     = 120;
   localparam int unsigned HOLD_CYCLES    = 90;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_ready = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_data;

   int unsigned failures;
   int unsigned outstanding;
   int unsigned stall_count  = 0;
   int unsigned answers_taken = 0;
   int unsigned hold_left    = 0;
   bit          long_hold_done = 1'b0;

   always #1 clock = ~clock;

   month_calendar_day_count i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   calendar_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // result side: random back-pressure, one long hold-off, a quiet stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) answers_taken++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (answers_taken == HOLD_AFTER && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (answers_taken >= QUIET_FIRST && answers_taken < QUIET_LAST) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else if (stall_count == STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   task automatic offer_query(input logic [YearWidth-1:0] year,
                              input logic [MonthWidth-1:0] month, input bit may_idle);
      if (may_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{year: year, month: month};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_for_answers();
      // one edge first so the count reflects the last accepted transaction
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic req_type pick_date();
      req_type     q;
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 45) begin
         q.year = 16'($urandom_range(2250, 1750));
      end else if (sel < 75) begin
         q.year = 16'($urandom_range(65535));
      end else if (sel < 88) begin
         q.year = 16'($urandom_range(2020, 2007));
      end else begin
         case ($urandom_range(5))
            0:       q.year = 16'd0;
            1:       q.year = 16'd1;
            2:       q.year = EPOCH_YEAR_M1;
            3:       q.year = EPOCH_YEAR;
            4:       q.year = 16'd65534;
            default: q.year = 16'd65535;
         endcase
      end
      if ($urandom_range(99) < 88)
         q.month = 4'($urandom_range(12, 1));
      else if ($urandom_range(3) == 0)
         q.month = 4'd0;
      else
         q.month = 4'($urandom_range(15, 13));
      return q;
   endfunction

   initial begin
      req_type q;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      offer_query(16'd0, 4'd1, 1'b1);
      offer_query(16'd0, MONTH_FEB, 1'b1);     // year zero counts as leap
      offer_query(16'd0, MONTH_DEC, 1'b1);
      offer_query(16'd1, 4'd1, 1'b1);
      offer_query(16'd1900, MONTH_FEB, 1'b1);  // century, not leap
      offer_query(16'd2000, MONTH_FEB, 1'b1);  // 400-year rule, leap
      offer_query(16'd2100, MONTH_FEB, 1'b1);
      offer_query(16'd2012, MONTH_FEB, 1'b1);
      offer_query(EPOCH_YEAR_M1, 4'd11, 1'b1);
      offer_query(EPOCH_YEAR_M1, MONTH_DEC, 1'b1);
      offer_query(EPOCH_YEAR, 4'd1, 1'b1);
      offer_query(EPOCH_YEAR, MONTH_DEC, 1'b1);
      offer_query(16'd2015, MONTH_FEB, 1'b1);
      offer_query(16'd2016, MONTH_FEB, 1'b1);
      offer_query(16'd65534, MONTH_FEB, 1'b1);
      offer_query(16'd65535, 4'd1, 1'b1);
      offer_query(16'd65535, MONTH_DEC, 1'b1);
      offer_query(EPOCH_YEAR, 4'd0, 1'b1);
      offer_query(EPOCH_YEAR_M1, 4'd0, 1'b1);
      offer_query(16'd65535, 4'd15, 1'b1);
      offer_query(16'd0, 4'd13, 1'b1);
      offer_query(16'd2000, 4'd14, 1'b1);

      for (int i = 0; i < RANDOM_QUERIES; i++) begin
         if (i == PAUSE_AT) begin
            req_valid <= 1'b0;
            wait_for_answers();
         end
         q = pick_date();
         offer_query(q.year, q.month, !(i >= QUIET_FIRST && i < QUIET_LAST));
      end
      req_valid <= 1'b0;

      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/mcdc_pkg.sv
rtl/core/month_calendar_day_count.sv
sim/calendar_checker.sv
sim/tb.sv
